// ===== rtl/bre_pkg.sv =====
// shared types, register codes and constants of the run rectangle extractor
package bre_pkg;

  // default sizes of the display and the source bitmap
  localparam int DEF_SCREEN_WIDTH    = 396;
  localparam int DEF_SCREEN_HEIGHT   = 224;
  localparam int DEF_MAX_IMAGE_WIDTH = 2048;
  localparam int MAX_IMAGE_HEIGHT    = 2048;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_LEFT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_TOP     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ZOOM_FACTOR  = 3'd4;

  // internal coordinate widths
  localparam int CRD_W  = 12;  // image sizes, rows, screen coordinates
  localparam int RX_W   = 11;  // viewport-relative x, up to the view width
  localparam int PIX_N  = 8;   // pixels per byte

  // geometry pipeline depth and span queue depth (power of two)
  localparam int GEO_LAT     = 5;
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [7:0] pixel_byte;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    logic [8:0] rect_left;
    logic [7:0] rect_top;
    logic [8:0] rect_right;
    logic [7:0] rect_bottom;
    logic       last_of_item;
  } out_item_t;

  // settled viewport geometry
  typedef struct packed {
    logic [CRD_W-1:0] w;
    logic [CRD_W-1:0] h;
    logic [CRD_W-1:0] pan_x;
    logic [CRD_W-1:0] pan_y;
    logic [CRD_W-1:0] vis_w;
    logic [CRD_W-1:0] vis_h;
    logic [CRD_W-1:0] dst_x;
    logic [CRD_W-1:0] dst_y;
    logic [1:0]       z;
  } geom_t;

  // closed runs of one byte: a flag per pixel where a run closes,
  // with its start and exclusive end in viewport x
  typedef struct packed {
    logic [PIX_N-1:0]           close;
    logic [PIX_N-1:0][RX_W-1:0] start;
    logic [PIX_N-1:0][RX_W-1:0] stop;
    logic [7:0]                 top;
    logic [7:0]                 bottom;
  } span_t;

endpackage

// ===== rtl/bre_geom.sv =====
// configuration registers and the pipelined viewport geometry
module bre_geom import bre_pkg::*; #(
  parameter int SCREEN_WIDTH    = DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT   = DEF_SCREEN_HEIGHT,
  parameter int MAX_IMAGE_WIDTH = DEF_MAX_IMAGE_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output geom_t                 geom,
  output logic                  busy
);

  localparam int CNT_W = $clog2(GEO_LAT + 1);
  localparam logic [CRD_W:0]   MAXW = (CRD_W+1)'(MAX_IMAGE_WIDTH);
  localparam logic [CRD_W:0]   MAXH = (CRD_W+1)'(MAX_IMAGE_HEIGHT);
  localparam logic [CRD_W-1:0] VW1  = CRD_W'(SCREEN_WIDTH);
  localparam logic [CRD_W-1:0] VW2  = CRD_W'(SCREEN_WIDTH / 2);
  localparam logic [CRD_W-1:0] VW3  = CRD_W'(SCREEN_WIDTH / 3);
  localparam logic [CRD_W-1:0] VH1  = CRD_W'(SCREEN_HEIGHT);
  localparam logic [CRD_W-1:0] VH2  = CRD_W'(SCREEN_HEIGHT / 2);
  localparam logic [CRD_W-1:0] VH3  = CRD_W'(SCREEN_HEIGHT / 3);
  localparam logic [CRD_W-1:0] SW_C = CRD_W'(SCREEN_WIDTH);
  localparam logic [CRD_W-1:0] SH_C = CRD_W'(SCREEN_HEIGHT);

  logic [11:0]      img_w_r;
  logic [11:0]      img_h_r;
  logic [10:0]      view_left_r;
  logic [10:0]      view_top_r;
  logic [1:0]       zoom_r;
  logic [CNT_W-1:0] settle_r;

  geom_t            a_nxt, a_r, b_nxt, b_r, c_nxt, c_r, d_nxt, d_r, e_nxt, e_r;
  logic [CRD_W-1:0] dw_c, dh_c;

  // register writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r     <= 12'd384;
      img_h_r     <= 12'd216;
      view_left_r <= '0;
      view_top_r  <= '0;
      zoom_r      <= 2'd1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  img_w_r     <= cfg_data;
        REG_IMAGE_HEIGHT: img_h_r     <= cfg_data;
        REG_VIEW_LEFT:    view_left_r <= cfg_data[10:0];
        REG_VIEW_TOP:     view_top_r  <= cfg_data[10:0];
        REG_ZOOM_FACTOR:  zoom_r      <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // hold off input until the geometry pipeline has seen the new registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_r <= CNT_W'(GEO_LAT);
    end else if (cfg_valid) begin
      settle_r <= CNT_W'(GEO_LAT);
    end else if (settle_r != '0) begin
      settle_r <= settle_r - 1'b1;
    end
  end

  assign busy = (settle_r != '0);

  // stage a: clamp sizes and zoom, view size; pan limit kept in pan_x/pan_y
  always_comb begin
    a_nxt = '0;
    a_nxt.w = (img_w_r == '0) ? CRD_W'(1) :
              (({1'b0, img_w_r} > MAXW) ? MAXW[CRD_W-1:0] : img_w_r);
    a_nxt.h = (img_h_r == '0) ? CRD_W'(1) :
              (({1'b0, img_h_r} > MAXH) ? MAXH[CRD_W-1:0] : img_h_r);
    a_nxt.z = (zoom_r == 2'd0) ? 2'd1 : zoom_r;
    unique case (a_nxt.z)
      2'd1: begin
        a_nxt.vis_w = VW1;
        a_nxt.vis_h = VH1;
      end
      2'd2: begin
        a_nxt.vis_w = VW2;
        a_nxt.vis_h = VH2;
      end
      default: begin
        a_nxt.vis_w = VW3;
        a_nxt.vis_h = VH3;
      end
    endcase
    a_nxt.pan_x = (a_nxt.w > a_nxt.vis_w) ? a_nxt.w - a_nxt.vis_w : '0;
    a_nxt.pan_y = (a_nxt.h > a_nxt.vis_h) ? a_nxt.h - a_nxt.vis_h : '0;
  end

  // stage b: clamp the requested pan to its limit
  always_comb begin
    b_nxt = a_r;
    b_nxt.pan_x = ({1'b0, view_left_r} > a_r.pan_x) ? a_r.pan_x : {1'b0, view_left_r};
    b_nxt.pan_y = ({1'b0, view_top_r} > a_r.pan_y) ? a_r.pan_y : {1'b0, view_top_r};
  end

  // stage c: visible size, view size capped by what is left of the image
  always_comb begin
    c_nxt = b_r;
    dw_c  = b_r.w - b_r.pan_x;
    dh_c  = b_r.h - b_r.pan_y;
    c_nxt.vis_w = (dw_c > b_r.vis_w) ? b_r.vis_w : dw_c;
    c_nxt.vis_h = (dh_c > b_r.vis_h) ? b_r.vis_h : dh_c;
  end

  // stage d: scaled visible size, kept in dst_x/dst_y
  always_comb begin
    d_nxt = c_r;
    d_nxt.dst_x = c_r.vis_w * CRD_W'(c_r.z);
    d_nxt.dst_y = c_r.vis_h * CRD_W'(c_r.z);
  end

  // stage e: centring offsets
  always_comb begin
    e_nxt = d_r;
    e_nxt.dst_x = (SW_C - d_r.dst_x) >> 1;
    e_nxt.dst_y = (SH_C - d_r.dst_y) >> 1;
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
    c_r <= c_nxt;
    d_r <= d_nxt;
    e_r <= e_nxt;
  end

  assign geom = e_r;

endmodule

// ===== rtl/bre_front.sv =====
// front end: row and column tracking, pixel scan and run closing per byte
module bre_front import bre_pkg::*; #(
  parameter int MAX_IMAGE_WIDTH = DEF_MAX_IMAGE_WIDTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  input  in_item_t in_item,
  output logic     in_full,
  input  geom_t    geom,
  input  logic     busy,
  input  logic     q_full,
  output logic     q_push,
  output span_t    q_data
);

  localparam int COL_W = $clog2(MAX_IMAGE_WIDTH / PIX_N);

  typedef struct packed {
    logic [7:0]       pix;
    logic [COL_W-1:0] col;
    logic [CRD_W-1:0] ry;
    logic             act;
    logic             vis;
    logic             row_end;
    logic             fs;
  } stage_t;

  logic [CRD_W-1:0] row_r, eff_row_c, ry_c;
  logic [COL_W-1:0] col_r, eff_col_c;
  logic [COL_W:0]   col_inc_c;
  logic [COL_W+3:0] col_end_px_c;
  logic             active_c, row_end_c, row_vis_c, accept_c;

  logic             s1_v_r;
  stage_t           s1_r;

  logic             run_open_r, open_c, open_nxt;
  logic [RX_W-1:0]  run_start_r, start_c;
  logic [CRD_W-1:0] x_c, rx_c, top_c;
  logic             pv_c, black_c, need_push_c, s1_go_c;
  span_t            span_c;

  // classify the incoming beat against the current row and column
  always_comb begin
    eff_row_c    = in_item.frame_start ? '0 : row_r;
    eff_col_c    = in_item.frame_start ? '0 : col_r;
    active_c     = (eff_row_c < geom.h);
    col_inc_c    = {1'b0, eff_col_c} + 1'b1;
    col_end_px_c = {col_inc_c, 3'b000};
    row_end_c    = ((CRD_W+1)'(col_end_px_c) >= {1'b0, geom.w});
    ry_c         = eff_row_c - geom.pan_y;
    row_vis_c    = (eff_row_c >= geom.pan_y) && (ry_c < geom.vis_h);
  end

  assign accept_c = in_push && !in_full;

  // row and column position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else if (accept_c && active_c) begin
      if (row_end_c) begin
        row_r <= eff_row_c + 1'b1;
        col_r <= '0;
      end else begin
        row_r <= eff_row_c;
        col_r <= col_inc_c[COL_W-1:0];
      end
    end
  end

  // classified beat register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (accept_c) begin
      s1_v_r <= 1'b1;
    end else if (s1_go_c) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept_c) begin
      s1_r.pix     <= in_item.pixel_byte;
      s1_r.col     <= eff_col_c;
      s1_r.ry      <= ry_c;
      s1_r.act     <= active_c;
      s1_r.vis     <= active_c && row_vis_c;
      s1_r.row_end <= row_end_c;
      s1_r.fs      <= in_item.frame_start;
    end
  end

  // walk the eight pixels, leftmost first, opening and closing runs
  always_comb begin
    open_c  = s1_r.fs ? 1'b0 : run_open_r;
    start_c = run_start_r;
    span_c  = '0;
    x_c     = '0;
    rx_c    = '0;
    pv_c    = 1'b0;
    black_c = 1'b0;
    for (int b = 0; b < PIX_N; b++) begin
      x_c     = CRD_W'({s1_r.col, 3'(b)});
      rx_c    = x_c - geom.pan_x;
      pv_c    = s1_r.vis && (x_c < geom.w) && (x_c >= geom.pan_x) && (rx_c < geom.vis_w);
      black_c = s1_r.pix[PIX_N-1-b];
      if (pv_c) begin
        if (black_c && !open_c) begin
          open_c  = 1'b1;
          start_c = rx_c[RX_W-1:0];
        end else if (!black_c && open_c) begin
          span_c.close[b] = 1'b1;
          span_c.start[b] = start_c;
          span_c.stop[b]  = rx_c[RX_W-1:0];
          open_c          = 1'b0;
        end
        // run reaching the right edge of the view
        if ((rx_c == geom.vis_w - 1'b1) && open_c) begin
          span_c.close[b] = 1'b1;
          span_c.start[b] = start_c;
          span_c.stop[b]  = rx_c[RX_W-1:0] + 1'b1;
          open_c          = 1'b0;
        end
      end
    end
    open_nxt = s1_r.row_end ? 1'b0 : open_c;
  end

  // scaled row top and bottom
  always_comb begin
    top_c         = geom.dst_y + s1_r.ry * CRD_W'(geom.z);
    q_data        = span_c;
    q_data.top    = top_c[7:0];
    q_data.bottom = 8'(top_c + CRD_W'(geom.z) - 1'b1);
  end

  assign need_push_c = (span_c.close != '0);
  assign s1_go_c     = s1_v_r && (!need_push_c || !q_full);
  assign q_push      = s1_v_r && need_push_c && !q_full;
  assign in_full     = busy || (s1_v_r && !s1_go_c);

  // open run carried from byte to byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_open_r  <= 1'b0;
      run_start_r <= '0;
    end else if (s1_go_c && s1_r.act) begin
      run_open_r  <= open_nxt;
      run_start_r <= start_c;
    end
  end

endmodule

// ===== rtl/bre_fifo.sv =====
// short queue of closed-run records between front and back end
module bre_fifo import bre_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  span_t wdata,
  output logic  full,
  input  logic  pop,
  output span_t rdata,
  output logic  empty
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  span_t            mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ===== rtl/bre_back.sv =====
// back end: one rectangle per cycle from the queued runs unless stalled
module bre_back import bre_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  span_t     head,
  input  logic      q_empty,
  output logic      q_pop,
  input  geom_t     geom,
  input  logic      out_pop,
  output logic      out_empty,
  output out_item_t out_item
);

  logic [PIX_N-1:0] taken_r, work_c, sel_oh_c;
  logic [2:0]       sel_c;
  logic [RX_W-1:0]  st_c, sp_c;
  logic [CRD_W-1:0] left_c, right_c;
  logic             last_c, adv_c, out_v_r;
  out_item_t        out_r;

  // lowest pending close of the head record
  always_comb begin
    work_c = head.close & ~taken_r;
    sel_c  = '0;
    for (int b = PIX_N - 1; b >= 0; b--) begin
      if (work_c[b]) begin
        sel_c = 3'(b);
      end
    end
    sel_oh_c = PIX_N'(1) << sel_c;
    last_c   = ((work_c & ~sel_oh_c) == '0);
    st_c     = head.start[sel_c];
    sp_c     = head.stop[sel_c];
    left_c   = geom.dst_x + CRD_W'(st_c) * CRD_W'(geom.z);
    right_c  = geom.dst_x + CRD_W'(sp_c) * CRD_W'(geom.z) - 1'b1;
  end

  assign adv_c     = !q_empty && (!out_v_r || out_pop);
  assign q_pop     = adv_c && last_c;
  assign out_empty = !out_v_r;
  assign out_item  = out_r;

  // output register and progress through the head record
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      taken_r <= '0;
    end else begin
      if (adv_c) begin
        out_v_r <= 1'b1;
        taken_r <= last_c ? '0 : (taken_r | sel_oh_c);
      end else if (out_pop) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_c) begin
      out_r.rect_left    <= left_c[8:0];
      out_r.rect_top     <= head.top;
      out_r.rect_right   <= right_c[8:0];
      out_r.rect_bottom  <= head.bottom;
      out_r.last_of_item <= last_c;
    end
  end

endmodule

// ===== rtl/bitmap_run_rect_extractor.sv =====
// top level of the bitmap run rectangle extractor
// Takes a packed 1-bit-per-pixel bitmap one byte per beat in raster order
// (bit 7 leftmost, rows padded to whole bytes) and emits every black run of
// each visible row as a zoomed, centred screen rectangle. The input side
// takes one byte per clock unless it reports full; a byte is classified
// as it is taken, registered and scanned in the next cycle; its closed
// runs go into a four-record queue. The back end turns one run into one
// rectangle per clock while results are popped, so the result port sets
// the sustained rate. After reset and every configuration write the input
// reports full while the geometry pipeline settles. The user must write
// configuration only while the block is idle; it is not enforced.
module bitmap_run_rect_extractor import bre_pkg::*; #(
  parameter int SCREEN_WIDTH    = DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT   = DEF_SCREEN_HEIGHT,
  parameter int MAX_IMAGE_WIDTH = DEF_MAX_IMAGE_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  input  in_item_t              in_item,
  output logic                  in_full,
  output logic                  out_empty,
  input  logic                  out_pop,
  output out_item_t             out_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  geom_t geom;
  logic  busy;
  logic  q_push, q_full, q_pop, q_empty;
  span_t q_wdata, q_rdata;

  assign cfg_ready = 1'b1;

  // configuration and geometry
  bre_geom #(
    .SCREEN_WIDTH    (SCREEN_WIDTH),
    .SCREEN_HEIGHT   (SCREEN_HEIGHT),
    .MAX_IMAGE_WIDTH (MAX_IMAGE_WIDTH)
  ) u_geom (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .geom      (geom),
    .busy      (busy)
  );

  // byte intake and run scan
  bre_front #(
    .MAX_IMAGE_WIDTH (MAX_IMAGE_WIDTH)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_item (in_item),
    .in_full (in_full),
    .geom    (geom),
    .busy    (busy),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_data  (q_wdata)
  );

  // run record queue
  bre_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  // rectangle output
  bre_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_rdata),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .geom      (geom),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_item  (out_item)
  );

endmodule
